// File: rtl/core/iir_lowpass_highpass_cascade_defines.svh
// Assertion macros for the IIR low-pass / high-pass cascade.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef IIR_LOWPASS_HIGHPASS_CASCADE_DEFINES_SVH
`define IIR_LOWPASS_HIGHPASS_CASCADE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define IIR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("iir cascade: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define IIR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("iir cascade: next-cycle check failed");

`endif

// File: rtl/core/iir_lhc_pkg.sv
// Package for the IIR low-pass / high-pass cascade: step table, command types.
// No dependencies.
`default_nettype none

package iir_lhc_pkg;

  localparam int unsigned LP_ORDER     = 4;
  localparam int unsigned HP_ORDER     = 3;
  localparam int unsigned LP_FRAC_BITS = 13;
  localparam int unsigned HP_FRAC_BITS = 12;
  localparam int unsigned COEF_W       = 16;
  localparam int unsigned DLY_DEPTH    = LP_ORDER + HP_ORDER;
  localparam int unsigned DLY_IDX_W    = $clog2(DLY_DEPTH);
  localparam int unsigned NUM_STEPS    = 2 * (LP_ORDER + HP_ORDER) + 2;
  localparam int unsigned STEP_W       = $clog2(NUM_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  typedef enum logic [1:0] {
    OPND_SAMPLE = 2'd0,
    OPND_LP     = 2'd1,
    OPND_HP     = 2'd2
  } opnd_e;

  typedef enum logic [1:0] {
    MODE_LOAD_D    = 2'd0,
    MODE_LOAD_ZERO = 2'd1,
    MODE_SUB       = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    YCAP_NONE = 2'd0,
    YCAP_LP   = 2'd1,
    YCAP_HP   = 2'd2
  } ycap_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    opnd_e                    opnd;
    mode_e                    mode;
    logic [DLY_IDX_W-1:0]     didx;  // delay read index (load) or write index (sub)
    ycap_e                    ycap;
  } step_t;

  typedef struct packed {
    logic  load_in;
    logic  mul_en;
    logic  acc_en;
    logic  ycap_en;
    logic  out_load;
    step_t step;
  } cmd_t;

  // Micro-program: low-pass stage in steps 0..8, high-pass in 9..15.
  function automatic step_t step_info(input logic [STEP_W-1:0] s);
    step_t r;
    case (s)
      4'd0:    r = '{ 16'sd26,     OPND_SAMPLE, MODE_LOAD_D,    3'd0, YCAP_LP   };
      4'd1:    r = '{ 16'sd105,    OPND_SAMPLE, MODE_LOAD_D,    3'd1, YCAP_NONE };
      4'd2:    r = '{ -16'sd20874, OPND_LP,     MODE_SUB,       3'd0, YCAP_NONE };
      4'd3:    r = '{ 16'sd158,    OPND_SAMPLE, MODE_LOAD_D,    3'd2, YCAP_NONE };
      4'd4:    r = '{ 16'sd21380,  OPND_LP,     MODE_SUB,       3'd1, YCAP_NONE };
      4'd5:    r = '{ 16'sd105,    OPND_SAMPLE, MODE_LOAD_D,    3'd3, YCAP_NONE };
      4'd6:    r = '{ -16'sd10134, OPND_LP,     MODE_SUB,       3'd2, YCAP_NONE };
      4'd7:    r = '{ 16'sd26,     OPND_SAMPLE, MODE_LOAD_ZERO, 3'd0, YCAP_NONE };
      4'd8:    r = '{ 16'sd1859,   OPND_LP,     MODE_SUB,       3'd3, YCAP_NONE };
      4'd9:    r = '{ 16'sd3540,   OPND_LP,     MODE_LOAD_D,    3'd4, YCAP_HP   };
      4'd10:   r = '{ -16'sd10621, OPND_LP,     MODE_LOAD_D,    3'd5, YCAP_NONE };
      4'd11:   r = '{ -16'sd11096, OPND_HP,     MODE_SUB,       3'd4, YCAP_NONE };
      4'd12:   r = '{ 16'sd10621,  OPND_LP,     MODE_LOAD_D,    3'd6, YCAP_NONE };
      4'd13:   r = '{ 16'sd10072,  OPND_HP,     MODE_SUB,       3'd5, YCAP_NONE };
      4'd14:   r = '{ -16'sd3540,  OPND_LP,     MODE_LOAD_ZERO, 3'd0, YCAP_NONE };
      4'd15:   r = '{ -16'sd3060,  OPND_HP,     MODE_SUB,       3'd6, YCAP_NONE };
      default: r = '{ 16'sd0,      OPND_SAMPLE, MODE_LOAD_ZERO, 3'd0, YCAP_NONE };
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/iir_lhc_ctrl.sv
// Sequencer for the IIR cascade: steps the shared multiply-accumulate through
// the micro-program and handles both handshakes. Depends on iir_lhc_pkg.
`default_nettype none

module iir_lhc_ctrl import iir_lhc_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  wire  out_stall_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL    = 5'b00010,
    ST_ACC    = 5'b00100,
    ST_YCALC  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               out_valid_q, out_valid_d;
  step_t              cur;

  assign cur = step_info(step_q);

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    cmd_o        = '0;
    cmd_o.step   = cur;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          step_d        = '0;
          state_d       = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (cur.ycap != YCAP_NONE) begin
          state_d = ST_YCALC;
        end else if (step_q == LAST_STEP) begin
          state_d = ST_FINISH;
        end else begin
          step_d  = step_q + 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_YCALC: begin
        cmd_o.ycap_en = 1'b1;
        step_d        = step_q + 1'b1;
        state_d       = ST_MUL;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/core/iir_lhc_datapath.sv
// Datapath for the IIR cascade: one multiplier, accumulator, delay registers,
// divide-and-saturate and the output registers. Depends on iir_lhc_pkg.
`default_nettype none

module iir_lhc_datapath import iir_lhc_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 24,
  parameter int unsigned STATE_WIDTH  = 48
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  cmd_t                           cmd_i,
  input  wire  signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic signed [SAMPLE_WIDTH-1:0] lowpass_out_o,
  output logic signed [SAMPLE_WIDTH-1:0] highpass_out_o
);

  localparam int unsigned SW = STATE_WIDTH;
  localparam int unsigned PW = SAMPLE_WIDTH + COEF_W;
  localparam int unsigned EW = (PW > SW) ? PW : SW;

  localparam logic [SW-1:0] LP_MASK = SW'((64'd1 << LP_FRAC_BITS) - 64'd1);
  localparam logic [SW-1:0] HP_MASK = SW'((64'd1 << HP_FRAC_BITS) - 64'd1);
  localparam logic signed [SW-1:0] Y_HI =
    {{(SW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] Y_LO = ~Y_HI;

  logic signed [SAMPLE_WIDTH-1:0] u_q, lp_q, hp_q, opnd, y_sat;
  logic signed [COEF_W-1:0]       coef;
  logic signed [PW-1:0]           prod;
  logic signed [EW-1:0]           p_ext;
  logic [SW-1:0]                  p_q, acc_q, acc_d, d_rd, bias, sum;
  logic signed [SW-1:0]           q;
  logic [SW-1:0]                  dly_q [DLY_DEPTH];
  logic                           is_lp;

  always_comb begin
    case (cmd_i.step.opnd)
      OPND_SAMPLE: opnd = u_q;
      OPND_LP:     opnd = lp_q;
      OPND_HP:     opnd = hp_q;
      default:     opnd = u_q;
    endcase
  end

  assign coef  = cmd_i.step.coef;
  assign prod  = coef * opnd;
  assign p_ext = EW'(prod);

  assign d_rd = dly_q[cmd_i.step.didx];

  always_comb begin
    case (cmd_i.step.mode)
      MODE_LOAD_D:    acc_d = d_rd + p_q;
      MODE_LOAD_ZERO: acc_d = p_q;
      MODE_SUB:       acc_d = acc_q - p_q;
      default:        acc_d = acc_q;
    endcase
  end

  // truncate toward zero: bias negatives before the arithmetic shift
  assign is_lp = (cmd_i.step.ycap == YCAP_LP);
  assign bias  = acc_q[SW-1] ? (is_lp ? LP_MASK : HP_MASK) : '0;
  assign sum   = acc_q + bias;
  assign q     = is_lp ? ($signed(sum) >>> LP_FRAC_BITS) : ($signed(sum) >>> HP_FRAC_BITS);

  always_comb begin
    if (q > Y_HI) begin
      y_sat = Y_HI[SAMPLE_WIDTH-1:0];
    end else if (q < Y_LO) begin
      y_sat = Y_LO[SAMPLE_WIDTH-1:0];
    end else begin
      y_sat = q[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) u_q <= sample_i;
    if (cmd_i.mul_en)  p_q <= p_ext[SW-1:0];
    if (cmd_i.acc_en)  acc_q <= acc_d;
    if (cmd_i.ycap_en) begin
      if (is_lp) begin
        lp_q <= y_sat;
      end else begin
        hp_q <= y_sat;
      end
    end
    if (cmd_i.out_load) begin
      lowpass_out_o  <= lp_q;
      highpass_out_o <= hp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DLY_DEPTH; i++) dly_q[i] <= '0;
    end else if (cmd_i.acc_en && (cmd_i.step.mode == MODE_SUB)) begin
      dly_q[cmd_i.step.didx] <= acc_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/iir_lowpass_highpass_cascade.sv
// Top level of the IIR low-pass (4th order) / high-pass (3rd order) cascade.
// Instantiates iir_lhc_ctrl and iir_lhc_datapath; uses iir_lhc_pkg and the defines header.
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+-------------------------------------
//   in      | in_valid_i  | in_stall_o  | sample_i
//   out     | out_valid_o | out_stall_i | lowpass_out_o, highpass_out_o
//
// Each beat is accepted in the idle state, then runs sixteen multiply-accumulate
// steps, each a multiply state and an accumulate state on the one shared multiplier,
// a divide-and-saturate state per filter stage and a hand-over before the next beat.
// Reset clears the delay line and control state; no clearing pass is needed.
// A result waits in the output register while the next beat is accepted.
// While that result stays stalled, the hand-over of the next one waits too.
`default_nettype none

`include "iir_lowpass_highpass_cascade_defines.svh"

module iir_lowpass_highpass_cascade import iir_lhc_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 24,
  parameter int unsigned STATE_WIDTH  = 48
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] lowpass_out_o,
  output logic signed [SAMPLE_WIDTH-1:0] highpass_out_o
);

  cmd_t cmd;

  iir_lhc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  iir_lhc_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .STATE_WIDTH  (STATE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sample_i       (sample_i),
    .lowpass_out_o  (lowpass_out_o),
    .highpass_out_o (highpass_out_o)
  );

  `IIR_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `IIR_ASSERT_NXT(a_no_instant_result, in_valid_i && !in_stall_o, !$rose(out_valid_o))
  `IIR_ASSERT_NXT(a_load_sets_valid, cmd.out_load, out_valid_o)
  `IIR_ASSERT_IMP(a_idle_on_result, $rose(out_valid_o), !in_stall_o)

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking bench for the low-pass / high-pass IIR cascade: each sample beat is
// run through a fixed-point cascade predictor and both outputs are compared in order.
// Depends on iir_lhc_pkg and the iir_lowpass_highpass_cascade top level.
`default_nettype none

module tb_top import iir_lhc_pkg::*; ();

  localparam int SAMPLE_W = 24;
  localparam int STATE_W = 48;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7fffff;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 24'sh800000;
  localparam longint SAT_HI = 64'sd8388607;
  localparam longint SAT_LO = -64'sd8388608;
  localparam int N_DIRECTED = 24;
  localparam int N_RANDOM = 950;
  localparam int HOLD_AT = 300;
  localparam int DRAIN_AT = 650;
  localparam int HOLD_CYCLES = 1500;
  localparam int TAIL_CYCLES = 100;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] lp;
    logic signed [SAMPLE_W-1:0] hp;
  } filt_out_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       fixed;
    logic signed [SAMPLE_W-1:0] lp;
    logic signed [SAMPLE_W-1:0] hp;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0] lowpass_out_o;
  logic signed [SAMPLE_W-1:0] highpass_out_o;

  always #2 clk_i = ~clk_i;

  iir_lowpass_highpass_cascade #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .STATE_WIDTH (STATE_W)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .lowpass_out_o (lowpass_out_o),
    .highpass_out_o(highpass_out_o)
  );

  // Section 0 is the low-pass stage, section 1 the high-pass stage.
  longint sec_b [2][5] = '{'{26, 105, 158, 105, 26}, '{3540, -10621, 10621, -3540, 0}};
  longint sec_a [2][5] = '{'{8192, -20874, 21380, -10134, 1859},
                           '{4096, -11096, 10072, -3060, 0}};
  int sec_order [2] = '{LP_ORDER, HP_ORDER};
  int sec_frac [2] = '{LP_FRAC_BITS, HP_FRAC_BITS};
  longint sec_dly [2][4] = '{'{0, 0, 0, 0}, '{0, 0, 0, 0}};

  filt_out_t pending_out[$];
  int n_errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_sat = 0;
  bit hold_req = 1'b0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{24'sd0, 1'b1, 24'sd0, 24'sd0},
    '{S_MAX, 1'b1, 24'sd26623, 24'sd23009},
    '{S_MIN, 1'b0, '0, '0},
    '{S_MIN, 1'b0, '0, '0},
    '{S_MAX, 1'b0, '0, '0},
    '{S_MAX, 1'b0, '0, '0},
    '{S_MAX, 1'b0, '0, '0},
    '{S_MAX, 1'b0, '0, '0},
    '{S_MAX, 1'b0, '0, '0},
    '{S_MAX, 1'b0, '0, '0},
    '{S_MAX, 1'b0, '0, '0},
    '{S_MAX, 1'b0, '0, '0},
    '{S_MIN, 1'b0, '0, '0},
    '{S_MIN, 1'b0, '0, '0},
    '{S_MIN, 1'b0, '0, '0},
    '{S_MIN, 1'b0, '0, '0},
    '{S_MIN, 1'b0, '0, '0},
    '{S_MIN, 1'b0, '0, '0},
    '{S_MIN, 1'b0, '0, '0},
    '{S_MIN, 1'b0, '0, '0},
    '{-24'sd1, 1'b0, '0, '0},
    '{24'sd1, 1'b0, '0, '0},
    '{24'sd0, 1'b0, '0, '0},
    '{24'sd16, 1'b0, '0, '0}
  };

  function automatic longint wrap_state(input longint v);
    logic signed [STATE_W-1:0] t;
    t = v[STATE_W-1:0];
    return t;
  endfunction

  // One transposed direct form II section; updates its delay line.
  function automatic longint filter_section(input int s, input longint u);
    longint acc, q, y;
    int n, k;
    n = sec_order[s];
    acc = wrap_state(sec_b[s][0] * u + sec_dly[s][0]);
    if (acc < 0) q = -((-acc) >>> sec_frac[s]);
    else q = acc >>> sec_frac[s];
    y = (q > SAT_HI) ? SAT_HI : (q < SAT_LO) ? SAT_LO : q;
    for (k = 1; k < n; k++) begin
      sec_dly[s][k-1] = wrap_state(sec_b[s][k] * u + sec_dly[s][k] - sec_a[s][k] * y);
    end
    sec_dly[s][n-1] = wrap_state(sec_b[s][n] * u - sec_a[s][n] * y);
    return y;
  endfunction

  function automatic filt_out_t predict_cascade(input logic signed [SAMPLE_W-1:0] s);
    filt_out_t r;
    longint lp, hp;
    lp = filter_section(0, longint'(s));
    hp = filter_section(1, lp);
    r.lp = lp[SAMPLE_W-1:0];
    r.hp = hp[SAMPLE_W-1:0];
    return r;
  endfunction

  function automatic int pick_idle(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 96) return $urandom_range(5, 40);
    return $urandom_range(41, 150);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    n_errors++;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit fixed,
                             input filt_out_t fixed_out);
    filt_out_t pred;
    in_valid_i <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pred = predict_cascade(s);
    pending_out.push_back(fixed ? fixed_out : pred);
    n_sent++;
  endtask

  task automatic idle_input(input int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    filt_out_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (pending_out.size() == 0) begin
        report_mismatch("result beat with nothing pending", lowpass_out_o, 0);
      end else begin
        want = pending_out.pop_front();
        if (lowpass_out_o !== want.lp) report_mismatch("lowpass_out", lowpass_out_o, want.lp);
        if (highpass_out_o !== want.hp)
          report_mismatch("highpass_out", highpass_out_o, want.hp);
        n_checked++;
        if (lowpass_out_o == S_MAX || lowpass_out_o == S_MIN) n_sat++;
      end
    end
  end

  initial begin : drive_out_stall
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(200, 600)) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 2) == 0);
        repeat (pick_idle(1'b0) + 1) @(posedge clk_i);
      end
    end
  end

  initial begin : drive_samples
    int i, j, chunk, mode, half, n_random, c;
    bit quiet;
    longint walk;
    logic signed [SAMPLE_W-1:0] s;
    n_random = 0;
    walk = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < N_DIRECTED; i++) begin
      send_sample(directed_rows[i].sample, directed_rows[i].fixed,
                  filt_out_t'{directed_rows[i].lp, directed_rows[i].hp});
      idle_input(pick_idle(1'b0));
    end

    while (n_random < N_RANDOM) begin
      chunk = $urandom_range(10, 60);
      mode = $urandom_range(0, 4);
      half = $urandom_range(5, 40);
      quiet = ($urandom_range(0, 3) == 0);
      for (j = 0; j < chunk && n_random < N_RANDOM; j++) begin
        if (n_random == HOLD_AT) hold_req = 1'b1;
        if (n_random == DRAIN_AT && pending_out.size() != 0) begin
          in_valid_i <= 1'b0;
          while (pending_out.size() != 0) @(posedge clk_i);
        end
        case (mode)
          0: s = SAMPLE_W'($urandom);
          1: s = SAMPLE_W'($signed($urandom_range(0, 4095)) - 2048);
          2: begin
            walk = walk + $signed($urandom_range(0, 65535)) - 32768;
            if (walk > SAT_HI) walk = SAT_HI;
            if (walk < SAT_LO) walk = SAT_LO;
            s = walk[SAMPLE_W-1:0];
          end
          3: s = ((j / half) % 2 == 0) ? S_MAX : S_MIN;
          default: begin
            case ($urandom_range(0, 4))
              0: s = S_MAX;
              1: s = S_MIN;
              2: s = '0;
              3: s = -24'sd1;
              default: s = 24'sd1;
            endcase
          end
        endcase
        send_sample(s, 1'b0, '0);
        n_random++;
        idle_input(hold_req ? 0 : pick_idle(quiet));
      end
    end

    in_valid_i <= 1'b0;
    for (c = 0; c < DRAIN_LIMIT && pending_out.size() != 0; c++) @(posedge clk_i);
    while (pending_out.size() != 0) begin
      report_mismatch("result never arrived", 0, pending_out[0].lp);
      void'(pending_out.pop_front());
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d samples (directed extremes, noise, walks, square bursts); checked %0d",
             n_sent, n_checked);
    $display("results, %0d with saturated low-pass output; %0d mismatches", n_sat, n_errors);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
